FILE: rtl/core/topological_sort_kahn_assert.svh
// Assertion macros for the topological sort block.
// Used by modules that sample on a port named clock and reset named reset.
`ifndef TOPOLOGICAL_SORT_KAHN_ASSERT_SVH
`define TOPOLOGICAL_SORT_KAHN_ASSERT_SVH
`ifndef SYNTHESIS
`define TSK_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("topological sort assertion failed");
`define TSK_ASSERT_ALWAYS(lbl, prop) \
   lbl: assert property (@(posedge clock) (prop)) \
      else $error("topological sort assertion failed");
`else
`define TSK_ASSERT(lbl, prop)
`define TSK_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

FILE: rtl/core/tsk_pkg.sv
// Shared constants and types of the topological sort block.
// No dependencies; used by the interfaces and topological_sort_kahn.
`default_nettype none
package tsk_pkg;
   localparam int MAX_NODES = 64;
   localparam int MAX_EDGES = 256;
   localparam int NODE_W    = $clog2(MAX_NODES);
   localparam int NCNT_W    = $clog2(MAX_NODES + 1);
   localparam int EDGE_W    = $clog2(MAX_EDGES);
   localparam int ECNT_W    = $clog2(MAX_EDGES + 1);
   localparam int DEP_W     = 32;
   localparam int STAT_W    = 3;

   typedef enum logic [STAT_W-1:0] {
      STAT_NODE     = 3'd0,
      STAT_EMPTY    = 3'd1,
      STAT_INVALID  = 3'd2,
      STAT_CYCLE    = 3'd3,
      STAT_CAPACITY = 3'd4
   } status_type;

   typedef enum logic [16:0] {
      S_IDLE   = 17'h00001,
      S_CHECK  = 17'h00002,
      S_CLR    = 17'h00004,
      S_CNT_A  = 17'h00008,
      S_CNT_B  = 17'h00010,
      S_CNT_C  = 17'h00020,
      S_SEED_A = 17'h00040,
      S_SEED_B = 17'h00080,
      S_POP_A  = 17'h00100,
      S_POP_B  = 17'h00200,
      S_SCAN_A = 17'h00400,
      S_SCAN_B = 17'h00800,
      S_SCAN_C = 17'h01000,
      S_VERIFY = 17'h02000,
      S_EMIT_A = 17'h04000,
      S_EMIT_B = 17'h08000,
      S_ERR    = 17'h10000
   } state_type;
endpackage
`default_nettype wire

FILE: rtl/core/tsk_req_if.sv
// Input channel of the topological sort block: valid, ready and one load item.
// Depends on tsk_pkg.
`default_nettype none
interface tsk_req_if;
   logic                     valid;
   logic                     ready;
   logic                     new_node;
   logic                     has_dep;
   logic [tsk_pkg::DEP_W-1:0] dep_id;
   logic                     last;
   modport source (output valid, new_node, has_dep, dep_id, last, input ready);
   modport sink   (input valid, new_node, has_dep, dep_id, last, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/tsk_rsp_if.sv
// Result channel of the topological sort block: valid, ready and one result item.
// Depends on tsk_pkg.
`default_nettype none
interface tsk_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [tsk_pkg::NODE_W-1:0] node_id;
   logic [tsk_pkg::STAT_W-1:0] status;
   logic                       final_res;
   modport source (output valid, node_id, status, final_res, input ready);
   modport sink   (input valid, node_id, status, final_res, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/tsk_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
`default_nettype none
module tsk_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

FILE: rtl/core/topological_sort_kahn.sv
// Kahn topological sort. Load items arrive one per cycle while the block is idle:
// each may open a new node (ids count up from zero) and may add one
// prerequisite to the newest node. The item marked last starts ordering, and the
// block takes no item until the run's final result has been loaded into the
// output register. Ordering clears the in-degree counts, counts in-degrees, seeds
// the ready queue in ascending id order, and for every popped node scans the whole
// edge store, all through one in-degree memory; the order is then read back from
// the queue, waiting when the result side stalls. A cycle in the graph, a
// prerequisite id at or above the node count, an empty graph or a capacity
// overflow gives one error item.
// Depends on tsk_pkg, the channel interfaces, tsk_ram and the assertion header.
`default_nettype none
`include "topological_sort_kahn_assert.svh"
module topological_sort_kahn (
   input wire logic clock,
   input wire logic reset,
   tsk_req_if.sink   req_ch,
   tsk_rsp_if.source rsp_ch
);
   import tsk_pkg::*;

   state_type state_ff, state_in;
   logic [NCNT_W-1:0] nc_ff, nc_in;
   logic [ECNT_W-1:0] ec_ff, ec_in;
   logic [DEP_W-1:0]  ld_ff, ld_in;
   logic              ovf_ff, ovf_in;
   logic [ECNT_W-1:0] idx_ff, idx_in;
   logic [NCNT_W-1:0] head_ff, head_in;
   logic [NCNT_W-1:0] tail_ff, tail_in;
   logic [NODE_W-1:0] cur_ff, cur_in;
   logic [NODE_W-1:0] dst_ff, dst_in;
   status_type        err_ff, err_in;

   logic              out_valid_ff, out_valid_in;
   logic [NODE_W-1:0] out_id_ff, out_id_in;
   status_type        out_stat_ff, out_stat_in;
   logic              out_fin_ff, out_fin_in;

   // Edge store: prerequisite in the upper field, dependent node in the lower.
   logic                  edge_we;
   logic [2*NODE_W-1:0]   edge_wdata, edge_rdata;
   logic [NODE_W-1:0]     edge_src, edge_dst;
   logic                  pend_we;
   logic [NODE_W-1:0]     pend_waddr, pend_raddr;
   logic [ECNT_W-1:0]     pend_wdata, pend_rdata, pend_dec;
   logic                  fifo_we;
   logic [NODE_W-1:0]     fifo_wdata, fifo_rdata;

   logic              accept, out_free, edge_last, node_last;
   logic [NCNT_W-1:0] nc_load;

   assign accept    = req_ch.valid && req_ch.ready;
   assign out_free  = !out_valid_ff || rsp_ch.ready;
   assign edge_src  = edge_rdata[2*NODE_W-1:NODE_W];
   assign edge_dst  = edge_rdata[NODE_W-1:0];
   assign edge_last = (idx_ff + ECNT_W'(1)) == ec_ff;
   assign node_last = (idx_ff[NCNT_W-1:0] + NCNT_W'(1)) == nc_ff;
   assign pend_dec  = pend_rdata - ECNT_W'(1);

   assign req_ch.ready     = (state_ff == S_IDLE);
   assign rsp_ch.valid     = out_valid_ff;
   assign rsp_ch.node_id   = out_id_ff;
   assign rsp_ch.status    = out_stat_ff;
   assign rsp_ch.final_res = out_fin_ff;

   tsk_ram #(.WIDTH(2*NODE_W), .DEPTH(MAX_EDGES)) u_edge_ram (
      .clock(clock), .wr_en(edge_we), .wr_addr(ec_ff[EDGE_W-1:0]),
      .wr_data(edge_wdata), .rd_addr(idx_ff[EDGE_W-1:0]), .rd_data(edge_rdata)
   );
   tsk_ram #(.WIDTH(ECNT_W), .DEPTH(MAX_NODES)) u_pend_ram (
      .clock(clock), .wr_en(pend_we), .wr_addr(pend_waddr),
      .wr_data(pend_wdata), .rd_addr(pend_raddr), .rd_data(pend_rdata)
   );
   tsk_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_fifo_ram (
      .clock(clock), .wr_en(fifo_we), .wr_addr(tail_ff[NODE_W-1:0]),
      .wr_data(fifo_wdata), .rd_addr(head_ff[NODE_W-1:0]), .rd_data(fifo_rdata)
   );

   always_comb begin
      state_in     = state_ff;
      nc_in        = nc_ff;
      ec_in        = ec_ff;
      ld_in        = ld_ff;
      ovf_in       = ovf_ff;
      idx_in       = idx_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      cur_in       = cur_ff;
      dst_in       = dst_ff;
      err_in       = err_ff;
      out_valid_in = out_valid_ff && !rsp_ch.ready;
      out_id_in    = out_id_ff;
      out_stat_in  = out_stat_ff;
      out_fin_in   = out_fin_ff;
      edge_we      = 1'b0;
      edge_wdata   = '0;
      pend_we      = 1'b0;
      pend_waddr   = dst_ff;
      pend_wdata   = '0;
      pend_raddr   = idx_ff[NODE_W-1:0];
      fifo_we      = 1'b0;
      fifo_wdata   = idx_ff[NODE_W-1:0];
      nc_load      = nc_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               // The new node is opened first, so an edge may attach to it.
               if (req_ch.new_node) begin
                  if (nc_ff >= NCNT_W'(MAX_NODES)) begin
                     ovf_in = 1'b1;
                  end else begin
                     nc_load = nc_ff + NCNT_W'(1);
                  end
               end
               nc_in = nc_load;
               if (req_ch.has_dep && nc_load != '0) begin
                  if (ec_ff >= ECNT_W'(MAX_EDGES)) begin
                     ovf_in = 1'b1;
                  end else begin
                     if (req_ch.dep_id > ld_ff) begin
                        ld_in = req_ch.dep_id;
                     end
                     edge_we = 1'b1;
                     edge_wdata[NODE_W-1:0] = NODE_W'(nc_load - NCNT_W'(1));
                     if (req_ch.dep_id < DEP_W'(MAX_NODES)) begin
                        edge_wdata[2*NODE_W-1:NODE_W] = req_ch.dep_id[NODE_W-1:0];
                     end
                     ec_in = ec_ff + ECNT_W'(1);
                  end
               end
               if (req_ch.last) begin
                  state_in = S_CHECK;
               end
            end
         end
         S_CHECK: begin
            idx_in  = '0;
            head_in = '0;
            tail_in = '0;
            if (ovf_ff) begin
               err_in   = STAT_CAPACITY;
               state_in = S_ERR;
            end else if (nc_ff == '0) begin
               err_in   = STAT_EMPTY;
               state_in = S_ERR;
            end else if (ld_ff >= DEP_W'(nc_ff)) begin
               err_in   = STAT_INVALID;
               state_in = S_ERR;
            end else begin
               state_in = S_CLR;
            end
         end
         S_CLR: begin
            pend_we    = 1'b1;
            pend_waddr = idx_ff[NODE_W-1:0];
            idx_in     = idx_ff + ECNT_W'(1);
            if (node_last) begin
               idx_in   = '0;
               state_in = (ec_ff == '0) ? S_SEED_A : S_CNT_A;
            end
         end
         S_CNT_A: begin
            state_in = S_CNT_B;
         end
         S_CNT_B: begin
            pend_raddr = edge_dst;
            dst_in     = edge_dst;
            state_in   = S_CNT_C;
         end
         S_CNT_C: begin
            pend_we    = 1'b1;
            pend_wdata = pend_rdata + ECNT_W'(1);
            idx_in     = idx_ff + ECNT_W'(1);
            state_in   = S_CNT_A;
            if (edge_last) begin
               idx_in   = '0;
               state_in = S_SEED_A;
            end
         end
         S_SEED_A: begin
            state_in = S_SEED_B;
         end
         S_SEED_B: begin
            if (pend_rdata == '0) begin
               fifo_we = 1'b1;
               tail_in = tail_ff + NCNT_W'(1);
            end
            idx_in   = idx_ff + ECNT_W'(1);
            state_in = node_last ? S_POP_A : S_SEED_A;
         end
         S_POP_A: begin
            state_in = (head_ff == tail_ff) ? S_VERIFY : S_POP_B;
         end
         S_POP_B: begin
            cur_in   = fifo_rdata;
            head_in  = head_ff + NCNT_W'(1);
            idx_in   = '0;
            state_in = (ec_ff == '0) ? S_POP_A : S_SCAN_A;
         end
         S_SCAN_A: begin
            state_in = S_SCAN_B;
         end
         S_SCAN_B: begin
            if (edge_src == cur_ff) begin
               pend_raddr = edge_dst;
               dst_in     = edge_dst;
               state_in   = S_SCAN_C;
            end else begin
               idx_in   = idx_ff + ECNT_W'(1);
               state_in = edge_last ? S_POP_A : S_SCAN_A;
            end
         end
         S_SCAN_C: begin
            pend_we    = 1'b1;
            pend_wdata = pend_dec;
            if (pend_dec == '0 && tail_ff < NCNT_W'(MAX_NODES)) begin
               fifo_we    = 1'b1;
               fifo_wdata = dst_ff;
               tail_in    = tail_ff + NCNT_W'(1);
            end
            idx_in   = idx_ff + ECNT_W'(1);
            state_in = edge_last ? S_POP_A : S_SCAN_A;
         end
         S_VERIFY: begin
            // Every node must have left the queue, or the graph has a cycle.
            head_in = '0;
            if (tail_ff == nc_ff) begin
               state_in = S_EMIT_A;
            end else begin
               err_in   = STAT_CYCLE;
               state_in = S_ERR;
            end
         end
         S_EMIT_A: begin
            state_in = S_EMIT_B;
         end
         S_EMIT_B: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_id_in    = fifo_rdata;
               out_stat_in  = STAT_NODE;
               out_fin_in   = (head_ff + NCNT_W'(1)) == nc_ff;
               head_in      = head_ff + NCNT_W'(1);
               state_in     = S_EMIT_A;
               if ((head_ff + NCNT_W'(1)) == nc_ff) begin
                  state_in = S_IDLE;
                  nc_in    = '0;
                  ec_in    = '0;
                  ld_in    = '0;
                  ovf_in   = 1'b0;
               end
            end
         end
         S_ERR: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_id_in    = '0;
               out_stat_in  = err_ff;
               out_fin_in   = 1'b1;
               state_in     = S_IDLE;
               nc_in        = '0;
               ec_in        = '0;
               ld_in        = '0;
               ovf_in       = 1'b0;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         nc_ff        <= '0;
         ec_ff        <= '0;
         ld_ff        <= '0;
         ovf_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
         idx_ff       <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         nc_ff        <= nc_in;
         ec_ff        <= ec_in;
         ld_ff        <= ld_in;
         ovf_ff       <= ovf_in;
         out_valid_ff <= out_valid_in;
         idx_ff       <= idx_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
      end
      cur_ff      <= cur_in;
      dst_ff      <= dst_in;
      err_ff      <= err_in;
      out_id_ff   <= out_id_in;
      out_stat_ff <= out_stat_in;
      out_fin_ff  <= out_fin_in;
   end

   // The queue never holds more nodes than the graph has.
   `TSK_ASSERT(a_tail_bound, (state_ff == S_VERIFY) |-> (tail_ff <= nc_ff))
   // A pop never runs past the queue's tail.
   `TSK_ASSERT(a_head_bound, (state_ff == S_POP_B) |-> (head_ff < tail_ff))
   // Returning to idle after a run leaves the loading state cleared.
   `TSK_ASSERT(a_run_cleared,
      (state_ff == S_IDLE && $past(state_ff) != S_IDLE) |-> (nc_ff == '0 && ec_ff == '0 && !ovf_ff))
endmodule
`default_nettype wire
